// ===== rtl/core/gsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// gsrc_pkg
// Shared types and constants of the greedy segment route cost block.
// ----------------------------------------------------------------------------
`default_nettype none

package gsrc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int WEIGHT_W   = 24;
  localparam int HOME_W     = 32;
  localparam int CHARGE_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOME_X          = 3'd0,
    REG_HOME_Y          = 3'd1,
    REG_INSPECT_WEIGHT  = 3'd2,
    REG_TRANSFER_WEIGHT = 3'd3,
    REG_ENERGY_PRICE    = 3'd4,
    REG_DISPATCH_CHARGE = 3'd5
  } cfg_reg_t;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 24'd65536;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/greedy_segment_route_cost.sv =====
// ----------------------------------------------------------------------------
// greedy_segment_route_cost
// Walks a run of segments from home, entering each at its nearer endpoint,
// and reports weighted energy and charge on the last segment.
//
// in_*  : one segment per request; in_tlast marks the last segment of a run.
// out_* : one result per segment; out_tlast = run done, out_tuser = forward.
// cfg_* : register writes (home, weights, price, dispatch charge), always ready.
// Requests go into a two-entry queue; the sequencer takes one at a time.
// Per segment: squaring on one shared multiplier plus two roots on the
// iterative root unit. The last segment adds the home leg (squaring and
// another root) and the weighted products.
// A stalled out_tready holds the result register; the queue keeps taking
// requests until full. Reset clears the totals and starts a new run at home;
// the weights and price reset to 1.0, home and dispatch charge to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_segment_route_cost #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int ACC_WIDTH   = 48
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // end_a_x, end_a_y, end_b_x, end_b_y
  input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0]  in_tdata,
  input  wire logic                                in_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // route_charge, energy_used
  output logic [((2*ACC_WIDTH+7)/8)*8-1:0]         out_tdata,
  // forward
  output logic                                     out_tuser,
  output logic                                     out_tlast,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [gsrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gsrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int QW  = 4 * CW + 1;
  localparam int ODW = ((2*ACC_WIDTH+7)/8)*8;

  logic [gsrc_pkg::HOME_W-1:0]   home_x_r, home_y_r;
  logic [gsrc_pkg::WEIGHT_W-1:0] inspect_weight_r, transfer_weight_r, energy_price_r;
  logic [gsrc_pkg::CHARGE_W-1:0] dispatch_charge_r;

  logic [CW+gsrc_pkg::HOME_W-1:0] home_x_pad, home_y_pad;
  logic                 q_full, q_valid, q_pop;
  logic [QW-1:0]        q_data;
  logic [ACC_WIDTH-1:0] charge, energy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_x_r          <= '0;
      home_y_r          <= '0;
      inspect_weight_r  <= gsrc_pkg::WEIGHT_ONE;
      transfer_weight_r <= gsrc_pkg::WEIGHT_ONE;
      energy_price_r    <= gsrc_pkg::WEIGHT_ONE;
      dispatch_charge_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gsrc_pkg::REG_HOME_X:          home_x_r <= cfg_data;
        gsrc_pkg::REG_HOME_Y:          home_y_r <= cfg_data;
        gsrc_pkg::REG_INSPECT_WEIGHT:  inspect_weight_r  <= cfg_data[gsrc_pkg::WEIGHT_W-1:0];
        gsrc_pkg::REG_TRANSFER_WEIGHT: transfer_weight_r <= cfg_data[gsrc_pkg::WEIGHT_W-1:0];
        gsrc_pkg::REG_ENERGY_PRICE:    energy_price_r    <= cfg_data[gsrc_pkg::WEIGHT_W-1:0];
        gsrc_pkg::REG_DISPATCH_CHARGE: dispatch_charge_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign home_x_pad = {{CW{1'b0}}, home_x_r};
  assign home_y_pad = {{CW{1'b0}}, home_y_r};

  assign in_tready = !q_full;

  gsrc_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && !q_full),
    .push_data ({in_tlast, in_tdata[4*CW-1:0]}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  gsrc_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .end_a_x          (q_data[CW-1:0]),
    .end_a_y          (q_data[2*CW-1:CW]),
    .end_b_x          (q_data[3*CW-1:2*CW]),
    .end_b_y          (q_data[4*CW-1:3*CW]),
    .run_last         (q_data[4*CW]),
    .home_x           (home_x_pad[CW-1:0]),
    .home_y           (home_y_pad[CW-1:0]),
    .inspect_weight   (inspect_weight_r),
    .transfer_weight  (transfer_weight_r),
    .energy_price     (energy_price_r),
    .dispatch_charge  (dispatch_charge_r),
    .out_ready        (out_tready),
    .out_valid        (out_tvalid),
    .out_forward      (out_tuser),
    .out_route_charge (charge),
    .out_energy_used  (energy),
    .out_run_done     (out_tlast)
  );

  assign out_tdata = ODW'({energy, charge});

endmodule

`default_nettype wire

// ===== rtl/core/gsrc_queue.sv =====
// ----------------------------------------------------------------------------
// gsrc_queue
// Two-entry request queue between the input side and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module gsrc_queue #(
  parameter int WIDTH = 129
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gsrc_sqrt.sv =====
// ----------------------------------------------------------------------------
// gsrc_sqrt
// Iterative integer square root, one root bit per cycle (floor result).
// ----------------------------------------------------------------------------
`default_nettype none

module gsrc_sqrt #(
  parameter int RTW = 33
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [2*RTW-1:0]   radicand,
  output logic [RTW-1:0]          root,
  output gsrc_pkg::sqrt_stat_t    stat
);

  localparam int CNT_W = $clog2(RTW + 1);

  logic [2*RTW-1:0] rad_r;
  logic [RTW+1:0]   rem_r;
  logic [RTW-1:0]   root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [RTW+3:0]   shifted;
  logic [RTW+3:0]   trial;
  logic             take;

  assign shifted = {rem_r, rad_r[2*RTW-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign take    = (shifted >= trial);

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNT_W'(RTW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r <= {rad_r[2*RTW-3:0], 2'b00};
        if (take) begin
          rem_r  <= (RTW+2)'(shifted - trial);
          root_r <= {root_r[RTW-2:0], 1'b1};
        end else begin
          rem_r  <= shifted[RTW+1:0];
          root_r <= {root_r[RTW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gsrc_back.sv =====
// ----------------------------------------------------------------------------
// gsrc_back
// Sequencer: squared distances on a shared multiplier, roots on the
// iterative unit, totals, weighted energy and charge, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gsrc_back #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int ACC_WIDTH   = 48
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  q_valid,
  output logic                                       q_pop,
  input  wire logic signed [COORD_WIDTH-1:0]         end_a_x,
  input  wire logic signed [COORD_WIDTH-1:0]         end_a_y,
  input  wire logic signed [COORD_WIDTH-1:0]         end_b_x,
  input  wire logic signed [COORD_WIDTH-1:0]         end_b_y,
  input  wire logic                                  run_last,
  input  wire logic signed [COORD_WIDTH-1:0]         home_x,
  input  wire logic signed [COORD_WIDTH-1:0]         home_y,
  input  wire logic [gsrc_pkg::WEIGHT_W-1:0]         inspect_weight,
  input  wire logic [gsrc_pkg::WEIGHT_W-1:0]         transfer_weight,
  input  wire logic [gsrc_pkg::WEIGHT_W-1:0]         energy_price,
  input  wire logic [gsrc_pkg::CHARGE_W-1:0]         dispatch_charge,
  input  wire logic                                  out_ready,
  output logic                                       out_valid,
  output logic                                       out_forward,
  output logic [ACC_WIDTH-1:0]                       out_route_charge,
  output logic [ACC_WIDTH-1:0]                       out_energy_used,
  output logic                                       out_run_done
);

  localparam int CW  = COORD_WIDTH;
  localparam int RTW = CW + 1;
  localparam int SQW = 2 * CW + 1;
  localparam int MW  = (CW > 32) ? CW : 32;
  localparam int PW  = 64 + gsrc_pkg::WEIGHT_W;
  localparam int SW  = ((ACC_WIDTH > RTW) ? ACC_WIDTH : RTW) + 1;
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_MUL, S_SQ_ACC, S_ROOT_T, S_ROOT_L, S_ROOT_H,
    S_SC_MUL, S_SC_ACC, S_EMIT
  } state_t;

  state_t state_r;

  logic signed [CW-1:0] ax_r, ay_r, bx_r, by_r, pos_x_r, pos_y_r;
  logic                 last_r, fwd_r, run_start_r;
  logic [SQW-1:0]       da_r, db_r, dl_r, dh_r;
  logic [ACC_WIDTH-1:0] ins_r, trn_r, ins_sc_r, energy_r, charge_r;
  logic [PW-1:0]        prod_r;
  logic [2:0]           step_r;
  logic                 sq_start_r;
  logic [2*MW-1:0]      p_r;

  logic                 out_valid_r, out_fwd_r, out_done_r;
  logic [ACC_WIDTH-1:0] out_charge_r, out_energy_r;

  logic [MW-1:0]        mul_a, mul_b;
  logic [2*MW-1:0]      p_nxt;
  logic [2*CW-1:0]      sq;
  logic [63:0]          chunk_src;
  logic [PW-1:0]        full;
  logic [PW-1:0]        scaled;
  logic [ACC_WIDTH-1:0] sat_s;
  logic [2*RTW-1:0]     radicand;
  logic [RTW-1:0]       root;
  gsrc_pkg::sqrt_stat_t sq_stat;

  function automatic logic [CW-1:0] abs_diff(logic signed [CW-1:0] a,
                                             logic signed [CW-1:0] b);
    logic [CW:0] d;
    d = {a[CW-1], a} - {b[CW-1], b};
    return d[CW] ? CW'(-d) : d[CW-1:0];
  endfunction

  function automatic logic [ACC_WIDTH-1:0] sat_acc(logic [SW-1:0] a, logic [SW-1:0] b);
    logic [SW-1:0] s;
    s = a + b;
    return (s > SW'(ACC_MAX)) ? ACC_MAX : s[ACC_WIDTH-1:0];
  endfunction

  always_comb begin
    mul_a     = '0;
    chunk_src = '0;
    mul_b     = '0;
    if (state_r == S_SC_MUL) begin
      case (step_r[2:1])
        2'd0: begin chunk_src = 64'(ins_r);    mul_b = MW'(inspect_weight);  end
        2'd1: begin chunk_src = 64'(trn_r);    mul_b = MW'(transfer_weight); end
        default: begin chunk_src = 64'(energy_r); mul_b = MW'(energy_price); end
      endcase
      mul_a = step_r[0] ? MW'(chunk_src[63:32]) : MW'(chunk_src[31:0]);
    end else begin
      case (step_r)
        3'd0:    mul_a = MW'(abs_diff(pos_x_r, ax_r));
        3'd1:    mul_a = MW'(abs_diff(pos_y_r, ay_r));
        3'd2:    mul_a = MW'(abs_diff(pos_x_r, bx_r));
        3'd3:    mul_a = MW'(abs_diff(pos_y_r, by_r));
        3'd4:    mul_a = MW'(abs_diff(ax_r, bx_r));
        3'd5:    mul_a = MW'(abs_diff(ay_r, by_r));
        3'd6:    mul_a = MW'(abs_diff(pos_x_r, home_x));
        default: mul_a = MW'(abs_diff(pos_y_r, home_y));
      endcase
      mul_b = mul_a;
    end
  end

  assign p_nxt  = mul_a * mul_b;
  assign sq     = p_r[2*CW-1:0];
  assign full   = prod_r + {p_r[PW-33:0], 32'b0};
  assign scaled = full >> FRAC_BITS;
  assign sat_s  = (scaled > PW'(ACC_MAX)) ? ACC_MAX : scaled[ACC_WIDTH-1:0];

  always_comb begin
    case (state_r)
      S_ROOT_T: radicand = (2*RTW)'(fwd_r ? da_r : db_r);
      S_ROOT_L: radicand = (2*RTW)'(dl_r);
      default:  radicand = (2*RTW)'(dh_r);
    endcase
  end

  gsrc_sqrt #(.RTW(RTW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start_r),
    .radicand (radicand),
    .root     (root),
    .stat     (sq_stat)
  );

  assign q_pop            = (state_r == S_IDLE) && q_valid;
  assign out_valid        = out_valid_r;
  assign out_forward      = out_fwd_r;
  assign out_route_charge = out_charge_r;
  assign out_energy_used  = out_energy_r;
  assign out_run_done     = out_done_r;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_start_r <= 1'b1;
      ins_r       <= '0;
      trn_r       <= '0;
      step_r      <= '0;
      sq_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sq_start_r <= 1'b0;
      if (out_valid_r && out_ready && (state_r != S_EMIT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            ax_r   <= end_a_x;
            ay_r   <= end_a_y;
            bx_r   <= end_b_x;
            by_r   <= end_b_y;
            last_r <= run_last;
            if (run_start_r) begin
              pos_x_r <= home_x;
              pos_y_r <= home_y;
              ins_r   <= '0;
              trn_r   <= '0;
            end
            step_r  <= 3'd0;
            state_r <= S_SQ_MUL;
          end
        end
        S_SQ_MUL: state_r <= S_SQ_ACC;
        S_SQ_ACC: begin
          case (step_r[2:1])
            2'd0: da_r <= step_r[0] ? SQW'(da_r + SQW'(sq)) : SQW'(sq);
            2'd1: db_r <= step_r[0] ? SQW'(db_r + SQW'(sq)) : SQW'(sq);
            2'd2: dl_r <= step_r[0] ? SQW'(dl_r + SQW'(sq)) : SQW'(sq);
            default: dh_r <= step_r[0] ? SQW'(dh_r + SQW'(sq)) : SQW'(sq);
          endcase
          if (step_r == 3'd5) begin
            fwd_r      <= (da_r <= db_r);
            sq_start_r <= 1'b1;
            state_r    <= S_ROOT_T;
          end else if (step_r == 3'd7) begin
            sq_start_r <= 1'b1;
            state_r    <= S_ROOT_H;
          end else begin
            step_r  <= step_r + 3'd1;
            state_r <= S_SQ_MUL;
          end
        end
        S_ROOT_T: begin
          if (sq_stat.done) begin
            trn_r      <= sat_acc(SW'(trn_r), SW'(root));
            sq_start_r <= 1'b1;
            state_r    <= S_ROOT_L;
          end
        end
        S_ROOT_L: begin
          if (sq_stat.done) begin
            ins_r   <= sat_acc(SW'(ins_r), SW'(root));
            pos_x_r <= fwd_r ? bx_r : ax_r;
            pos_y_r <= fwd_r ? by_r : ay_r;
            if (last_r) begin
              step_r  <= 3'd6;
              state_r <= S_SQ_MUL;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_ROOT_H: begin
          if (sq_stat.done) begin
            trn_r   <= sat_acc(SW'(trn_r), SW'(root));
            step_r  <= 3'd0;
            state_r <= S_SC_MUL;
          end
        end
        S_SC_MUL: state_r <= S_SC_ACC;
        S_SC_ACC: begin
          if (!step_r[0]) begin
            prod_r  <= PW'(p_r);
            step_r  <= step_r + 3'd1;
            state_r <= S_SC_MUL;
          end else begin
            case (step_r[2:1])
              2'd0:    ins_sc_r <= sat_s;
              2'd1:    energy_r <= sat_acc(SW'(ins_sc_r), SW'(sat_s));
              default: charge_r <= sat_acc(SW'(dispatch_charge), SW'(sat_s));
            endcase
            if (step_r == 3'd5) begin
              state_r <= S_EMIT;
            end else begin
              step_r  <= step_r + 3'd1;
              state_r <= S_SC_MUL;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_fwd_r    <= fwd_r;
            out_done_r   <= last_r;
            out_charge_r <= last_r ? charge_r : '0;
            out_energy_r <= last_r ? energy_r : '0;
            run_start_r  <= last_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
